// ===== design/slrw_pkg.sv =====
// Package with the shared codes and types of the segment layout checker.
package slrw_pkg;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_RELRO = 2'd2;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_NONADJ   = 2'd2;
  localparam logic [1:0] FAULT_RX_AFTER = 2'd3;

  localparam logic [2:0] ST_OK              = 3'd0;
  localparam logic [2:0] ST_MULTI_RELRO     = 3'd1;
  localparam logic [2:0] ST_NONADJ_RW       = 3'd2;
  localparam logic [2:0] ST_RX_AFTER_RW     = 3'd3;
  localparam logic [2:0] ST_RELRO_NOT_FIRST = 3'd4;
  localparam logic [2:0] ST_OVERFLOW        = 3'd5;
  localparam logic [2:0] ST_NO_RW           = 3'd6;

  localparam logic [4:0] PAGE_LOG2_RESET = 5'd12;

  typedef struct packed {
    logic [1:0]  kind;
    logic        rd;
    logic        wr;
    logic        ex;
    logic [63:0] addr;
    logic        last;
    logic [63:0] end_addr;
    logic        end_ovf;
  } entry_t;

  typedef struct packed {
    logic [1:0]  relro_count;
    logic [63:0] ro_base;
    logic [63:0] ro_limit;
    logic        ro_limit_ovf;
    logic        rw_seen;
    logic [63:0] first_rw_addr;
    logic        prev_was_rw;
    logic        rx_seen;
    logic        latest_was_rx;
    logic [1:0]  layout_fault;
  } trk_t;

  typedef struct packed {
    logic        eligible;
    logic [2:0]  status;
    logic [63:0] boundary;
  } res_t;

endpackage

// ===== design/slrw_if.sv =====
// Channel interfaces for header entries, results and the configuration write.
interface slrw_entry_if;
  logic        valid;
  logic        ready;
  logic [1:0]  entry_kind;
  logic        can_read;
  logic        can_write;
  logic        can_exec;
  logic [63:0] virt_addr;
  logic [63:0] mem_size;
  logic        is_last;

  modport source (output valid, entry_kind, can_read, can_write, can_exec, virt_addr,
                  mem_size, is_last, input ready);
  modport sink (input valid, entry_kind, can_read, can_write, can_exec, virt_addr,
                mem_size, is_last, output ready);
endinterface

interface slrw_result_if;
  logic        valid;
  logic        ready;
  logic        eligible;
  logic [2:0]  status;
  logic [63:0] boundary;

  modport source (output valid, eligible, status, boundary, input ready);
  modport sink (input valid, eligible, status, boundary, output ready);
endinterface

interface slrw_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/slrw_in_stage.sv =====
// Input register for header entries, with the segment end sum formed on capture.
module slrw_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  slrw_entry_if.sink           entry_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output slrw_pkg::entry_t     entry_o
);

  logic             valid_q;
  slrw_pkg::entry_t entry_q;
  slrw_pkg::entry_t entry_d;
  logic [64:0]      sum;

  assign entry_i.ready = !valid_q || advance_i;

  always_comb begin
    sum = {1'b0, entry_i.virt_addr} + {1'b0, entry_i.mem_size};
    entry_d.kind     = entry_i.entry_kind;
    entry_d.rd       = entry_i.can_read;
    entry_d.wr       = entry_i.can_write;
    entry_d.ex       = entry_i.can_exec;
    entry_d.addr     = entry_i.virt_addr;
    entry_d.last     = entry_i.is_last;
    entry_d.end_addr = sum[63:0];
    entry_d.end_ovf  = sum[64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (entry_i.valid && entry_i.ready) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_i.valid && entry_i.ready) begin
      entry_q <= entry_d;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ===== design/slrw_tracker.sv =====
// Per-table layout state: relro capture, read-write adjacency and ordering faults.
module slrw_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  slrw_pkg::entry_t entry_i,
  output slrw_pkg::trk_t   trk_o
);

  slrw_pkg::trk_t trk_q;
  slrw_pkg::trk_t trk_d;
  logic           this_rw;
  logic           is_rw;
  logic           is_rx;

  always_comb begin
    trk_d   = trk_q;
    this_rw = 1'b0;
    is_rw   = entry_i.rd && entry_i.wr;
    is_rx   = entry_i.rd && entry_i.ex;
    if (entry_i.kind == slrw_pkg::KIND_RELRO) begin
      if (trk_q.relro_count == 2'd0) begin
        trk_d.ro_base      = entry_i.addr;
        trk_d.ro_limit     = entry_i.end_addr;
        trk_d.ro_limit_ovf = entry_i.end_ovf;
      end
      if (trk_q.relro_count != 2'd2) begin
        trk_d.relro_count = trk_q.relro_count + 2'd1;
      end
    end else if (entry_i.kind == slrw_pkg::KIND_LOAD) begin
      this_rw = is_rw;
      if (trk_q.layout_fault == slrw_pkg::FAULT_NONE) begin
        if (is_rw) begin
          if (trk_q.rw_seen && !trk_q.prev_was_rw) begin
            trk_d.layout_fault = slrw_pkg::FAULT_NONADJ;
          end else begin
            if (!trk_q.rw_seen) begin
              trk_d.first_rw_addr = entry_i.addr;
            end
            trk_d.rw_seen       = 1'b1;
            trk_d.latest_was_rx = 1'b0;
          end
        end else if (is_rx) begin
          if (trk_q.rx_seen && trk_q.rw_seen && !trk_q.latest_was_rx) begin
            trk_d.layout_fault = slrw_pkg::FAULT_RX_AFTER;
          end else begin
            trk_d.rx_seen       = 1'b1;
            trk_d.latest_was_rx = 1'b1;
          end
        end
      end
    end
    trk_d.prev_was_rw = this_rw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= '0;
    end else if (fire_i) begin
      trk_q <= entry_i.last ? '0 : trk_d;
    end
  end

  assign trk_o = trk_d;

endmodule

// ===== design/slrw_verdict.sv =====
// Closing check of a table: status priority and the aligned code/data boundary.
module slrw_verdict (
  input  slrw_pkg::trk_t trk_i,
  input  logic [4:0]     page_log2_i,
  output slrw_pkg::res_t res_o
);

  logic [63:0] mask;
  logic [64:0] up;
  logic [2:0]  status;
  logic [63:0] boundary;

  always_comb begin
    mask     = (64'd1 << page_log2_i) - 64'd1;
    up       = {1'b0, trk_i.ro_limit} + {1'b0, mask};
    status   = slrw_pkg::ST_OK;
    boundary = '0;
    if (trk_i.relro_count == 2'd2) begin
      status = slrw_pkg::ST_MULTI_RELRO;
    end else if (trk_i.layout_fault != slrw_pkg::FAULT_NONE) begin
      status = {1'b0, trk_i.layout_fault};
    end else if (!trk_i.rw_seen) begin
      status = slrw_pkg::ST_NO_RW;
    end else if (trk_i.relro_count == 2'd0) begin
      boundary = trk_i.first_rw_addr & ~mask;
    end else if (trk_i.first_rw_addr != trk_i.ro_base) begin
      status = slrw_pkg::ST_RELRO_NOT_FIRST;
    end else if (trk_i.ro_limit_ovf || up[64]) begin
      status = slrw_pkg::ST_OVERFLOW;
    end else begin
      boundary = up[63:0] & ~mask;
    end
    res_o.eligible = (status == slrw_pkg::ST_OK);
    res_o.status   = status;
    res_o.boundary = (status == slrw_pkg::ST_OK) ? boundary : 64'd0;
  end

endmodule

// ===== design/segment_layout_rx_rw_checker_core.sv =====
// Top level of the segment layout checker for code/data split loading.
//
//   channel   modport  carries
//   entry_i   sink     one program header entry per transfer
//   result_o  source   eligible, status and boundary after the last entry
//   cfg_i     sink     page_size_log2, always ready
//
// An entry is held in the input register; the tracker and closing check sit
// between it and the result register, which loads when a last entry leaves.
// A new entry can be accepted every cycle unless a last entry waits. Reset
// clears the table state and sets page_size_log2 to 12. Only a last entry waits,
// while the result register is full and not taken; the input register then holds it.
module segment_layout_rx_rw_checker_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  slrw_entry_if.sink   entry_i,
  slrw_result_if.source result_o,
  slrw_cfg_if.sink     cfg_i
);

  logic             in_valid;
  slrw_pkg::entry_t entry;
  logic             fire;
  logic             out_free;
  slrw_pkg::trk_t   trk;
  slrw_pkg::res_t   res;
  logic [4:0]       page_log2_q;
  logic             out_valid_q;
  slrw_pkg::res_t   res_q;

  assign out_free = !out_valid_q || result_o.ready;
  assign fire     = in_valid && (!entry.last || out_free);
  assign cfg_i.ready = 1'b1;

  slrw_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .entry_i   (entry_i),
    .advance_i (fire),
    .valid_o   (in_valid),
    .entry_o   (entry)
  );

  slrw_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .entry_i (entry),
    .trk_o   (trk)
  );

  slrw_verdict u_verdict (
    .trk_i       (trk),
    .page_log2_i (page_log2_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_log2_q <= slrw_pkg::PAGE_LOG2_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      page_log2_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && entry.last) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && entry.last) begin
      res_q <= res;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.eligible = res_q.eligible;
  assign result_o.status   = res_q.status;
  assign result_o.boundary = res_q.boundary;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && entry.last |=> out_valid_q)
    else $error("last entry did not load the result register");

  a_inner_never_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !entry.last |-> fire)
    else $error("an entry without the last mark was held back");

  a_eligible_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.eligible == (res_q.status == slrw_pkg::ST_OK))
    else $error("eligible disagrees with status");

  a_boundary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.eligible |-> res_q.boundary == 64'd0)
    else $error("boundary not zero on an ineligible table");

endmodule

// ===== verif/segment_layout_rx_rw_checker_core_test.sv =====
// Testbench for the segment layout checker: header tables in, layout verdicts checked.
module segment_layout_rx_rw_checker_core_test;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 120;

  typedef struct packed {
    logic [1:0]  kind;
    logic        rd;
    logic        wr;
    logic        ex;
    logic [63:0] addr;
    logic [63:0] size;
    logic        last;
  } hdr_entry_t;

  logic clk_i;
  logic rst_ni;

  slrw_entry_if  entry_if ();
  slrw_result_if result_if ();
  slrw_cfg_if    cfg_if ();

  segment_layout_rx_rw_checker_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (entry_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  // Layout tracker state, cleared after every table.
  logic [4:0]  page_log2;
  logic [1:0]  relro_cnt;
  logic [63:0] relro_base;
  logic [63:0] relro_len;
  logic        have_rw;
  logic [63:0] rw_base;
  logic        prev_rw;
  logic        have_rx;
  logic        rx_latest;
  logic [1:0]  fault;

  slrw_pkg::res_t verdict_q[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  int   cycles = 0;
  int   hold_token = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   rx_tick = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_tracker();
    relro_cnt  = '0;
    relro_base = '0;
    relro_len  = '0;
    have_rw    = 1'b0;
    rw_base    = '0;
    prev_rw    = 1'b0;
    have_rx    = 1'b0;
    rx_latest  = 1'b0;
    fault      = slrw_pkg::FAULT_NONE;
  endfunction

  function automatic void track_layout_entry(hdr_entry_t e);
    logic           rw_now;
    logic [63:0]    mask;
    logic [64:0]    ro_limit;
    slrw_pkg::res_t v;
    rw_now = 1'b0;
    if (e.kind == slrw_pkg::KIND_RELRO) begin
      if (relro_cnt == 2'd0) begin
        relro_base = e.addr;
        relro_len  = e.size;
      end
      if (relro_cnt < 2'd2) relro_cnt++;
    end else if (e.kind == slrw_pkg::KIND_LOAD && fault == slrw_pkg::FAULT_NONE) begin
      if (e.rd && e.wr) begin
        rw_now = 1'b1;
        if (have_rw && !prev_rw) begin
          fault = slrw_pkg::FAULT_NONADJ;
        end else begin
          if (!have_rw) rw_base = e.addr;
          have_rw   = 1'b1;
          rx_latest = 1'b0;
        end
      end else if (e.rd && e.ex) begin
        if (have_rx && have_rw && !rx_latest) begin
          fault = slrw_pkg::FAULT_RX_AFTER;
        end else begin
          have_rx   = 1'b1;
          rx_latest = 1'b1;
        end
      end
    end else if (e.kind == slrw_pkg::KIND_LOAD && e.rd && e.wr) begin
      rw_now = 1'b1;
    end
    prev_rw = rw_now;
    if (!e.last) return;

    mask = (64'd1 << page_log2) - 64'd1;
    v.status   = slrw_pkg::ST_OK;
    v.boundary = '0;
    if (relro_cnt >= 2'd2) begin
      v.status = slrw_pkg::ST_MULTI_RELRO;
    end else if (fault == slrw_pkg::FAULT_NONADJ) begin
      v.status = slrw_pkg::ST_NONADJ_RW;
    end else if (fault == slrw_pkg::FAULT_RX_AFTER) begin
      v.status = slrw_pkg::ST_RX_AFTER_RW;
    end else if (!have_rw) begin
      v.status = slrw_pkg::ST_NO_RW;
    end else if (relro_cnt == 2'd0) begin
      v.boundary = rw_base & ~mask;
    end else if (rw_base != relro_base) begin
      v.status = slrw_pkg::ST_RELRO_NOT_FIRST;
    end else begin
      ro_limit = {1'b0, relro_base} + {1'b0, relro_len};
      if (ro_limit[64] || ro_limit[63:0] > ~mask) v.status = slrw_pkg::ST_OVERFLOW;
      else v.boundary = (ro_limit[63:0] + mask) & ~mask;
    end
    v.eligible = (v.status == slrw_pkg::ST_OK);
    if (!v.eligible) v.boundary = '0;
    verdict_q.push_back(v);
    clear_tracker();
  endfunction

  function automatic hdr_entry_t hdr(logic [1:0] kind, logic rd, logic wr, logic ex,
                                     logic [63:0] addr, logic [63:0] size, logic last);
    hdr_entry_t e;
    e.kind = kind;
    e.rd   = rd;
    e.wr   = wr;
    e.ex   = ex;
    e.addr = addr;
    e.size = size;
    e.last = last;
    return e;
  endfunction

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return {32'hFFFF_FFFF, $urandom};
      2: return {32'd0, $urandom};
      default: return {$urandom, 32'd0};
    endcase
  endfunction

  function automatic logic [63:0] pick_size();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return 64'($urandom_range(0, 32'h0010_0000));
  endfunction

  task automatic send_entry(hdr_entry_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        entry_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    entry_if.valid      <= 1'b1;
    entry_if.entry_kind <= e.kind;
    entry_if.can_read   <= e.rd;
    entry_if.can_write  <= e.wr;
    entry_if.can_exec   <= e.ex;
    entry_if.virt_addr  <= e.addr;
    entry_if.mem_size   <= e.size;
    entry_if.is_last    <= e.last;
    do @(posedge clk_i); while (entry_if.ready !== 1'b1);
    track_layout_entry(e);
    items_sent++;
  endtask

  task automatic wait_drained();
    entry_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_page_log2(logic [4:0] value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    page_log2 = value;
  endtask

  task automatic check_verdict();
    slrw_pkg::res_t want;
    if (verdict_q.size() == 0) begin
      $error("result transfer with no verdict expected");
      mismatches++;
      return;
    end
    want = verdict_q.pop_front();
    if (result_if.eligible !== want.eligible) begin
      $error("eligible: expected %0d, got %0d", want.eligible, result_if.eligible);
      mismatches++;
    end
    if (result_if.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, result_if.status);
      mismatches++;
    end
    if (result_if.boundary !== want.boundary) begin
      $error("boundary: expected %h, got %h", want.boundary, result_if.boundary);
      mismatches++;
    end
  endtask

  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid === 1'b1 && result_if.ready === 1'b1) check_verdict();
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        case ((rx_tick / 97) % 3)
          0: result_if.ready <= 1'b1;
          1: result_if.ready <= ($urandom_range(0, 3) != 0);
          default: result_if.ready <= rx_tick[2];
        endcase
      end
      rx_tick++;
    end
  end

  task automatic run_random_table();
    hdr_entry_t  tbl[$];
    logic [63:0] base;
    int          shape;
    int          relro_plan;
    int          n_rw;
    base = pick_addr();
    shape = $urandom_range(0, 9);
    if (shape >= 8) begin
      repeat ($urandom_range(1, 6))
        tbl.push_back(hdr(2'($urandom_range(slrw_pkg::KIND_OTHER, KIND_SPARE)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_addr(), pick_size(),
                          $urandom_range(0, 3) == 0));
    end else begin
      relro_plan = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0)
        tbl.push_back(hdr(slrw_pkg::KIND_OTHER, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          pick_addr(), pick_size(), 1'b0));
      repeat ($urandom_range(0, 2))
        tbl.push_back(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b0, 1'b1, pick_addr(), pick_size(),
                          1'b0));
      if (relro_plan == 1) tbl.push_back(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, base,
                                             pick_size(), 1'b0));
      n_rw = $urandom_range(1, 3);
      for (int k = 0; k < n_rw; k++) begin
        tbl.push_back(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'($urandom_range(0, 1)),
                          (k == 0) ? base : pick_addr(), pick_size(), 1'b0));
        if (shape == 7 && k == 0) begin
          if ($urandom_range(0, 1) == 0)
            tbl.push_back(hdr(slrw_pkg::KIND_OTHER, 1'b0, 1'b0, 1'b0, pick_addr(),
                              pick_size(), 1'b0));
          else
            tbl.push_back(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b0, 1'b1, pick_addr(),
                              pick_size(), 1'b0));
        end
      end
      case (relro_plan)
        2, 3: tbl.push_back(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, base, pick_size(),
                                1'b0));
        4: begin
          tbl.push_back(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, base, pick_size(), 1'b0));
          tbl.push_back(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, pick_addr(), pick_size(),
                            1'b0));
        end
        5: tbl.push_back(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, base ^ 64'h1000,
                             pick_size(), 1'b0));
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        tbl.push_back(hdr(slrw_pkg::KIND_OTHER, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          pick_addr(), pick_size(), 1'b0));
    end
    tbl[tbl.size() - 1].last = 1'b1;
    foreach (tbl[k]) send_entry(tbl[k]);
  endtask

  task automatic test_directed_cases();
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b0, 1'b1, 1'b1, 64'h0, 64'h0, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, 64'h0040_0000, 64'h100, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b0, 1'b1, 64'h1000, 64'h2000, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b1, 64'h0040_2345, 64'h5000, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, 64'h0040_2345, 64'h1234, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, '1, '1, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_RELRO, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, 64'h8000, 64'h10, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, 64'h9000, 64'h10, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'h8000, 64'h10, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'h1_0000, 64'h10, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_OTHER, 1'b1, 1'b1, 1'b1, 64'h2_0000, 64'h10, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'h3_0000, 64'h10, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b0, 1'b1, 64'h1000, 64'h10, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'h5000, 64'h10, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b0, 1'b1, 64'h9000, 64'h10, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'h7000, 64'h10, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, 64'h7008, 64'h10, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_F000, 64'h10,
                   1'b0));
    send_entry(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_F000,
                   64'h1000, 1'b1));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_E000, 64'h10,
                   1'b0));
    send_entry(hdr(slrw_pkg::KIND_RELRO, 1'b1, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_E000,
                   64'h1001, 1'b1));
    send_entry(hdr(KIND_SPARE, 1'b1, 1'b1, 1'b1, '1, '1, 1'b0));
    send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'b0, 64'h0123_4567_89AB_CDEF, 64'h10,
                   1'b1));
  endtask

  task automatic test_random_tables(logic [4:0] value, int n_items);
    int target;
    write_page_log2(value);
    target = items_sent + n_items;
    while (items_sent < target) run_random_table();
  endtask

  task automatic test_result_hold_off();
    wait_drained();
    hold_token <= hold_token + 1;
    repeat (30)
      send_entry(hdr(slrw_pkg::KIND_LOAD, 1'b1, 1'b1, 1'($urandom_range(0, 1)), pick_addr(),
                     pick_size(), 1'b1));
    wait_drained();
  endtask

  initial begin
    rst_ni              <= 1'b0;
    entry_if.valid      <= 1'b0;
    entry_if.entry_kind <= slrw_pkg::KIND_OTHER;
    entry_if.can_read   <= 1'b0;
    entry_if.can_write  <= 1'b0;
    entry_if.can_exec   <= 1'b0;
    entry_if.virt_addr  <= '0;
    entry_if.mem_size   <= '0;
    entry_if.is_last    <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= slrw_pkg::PAGE_LOG2_RESET;
    page_log2 = slrw_pkg::PAGE_LOG2_RESET;
    clear_tracker();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_tables(slrw_pkg::PAGE_LOG2_RESET, 100);
    test_random_tables(5'd16, 80);
    test_random_tables(5'd0, 60);
    test_random_tables(5'd31, 60);
    test_random_tables(5'd13, 80);
    test_result_hold_off();
    wait_drained();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== segment_layout_rx_rw_checker_core.f =====
design/slrw_pkg.sv
design/slrw_if.sv
design/slrw_in_stage.sv
design/slrw_tracker.sv
design/slrw_verdict.sv
design/segment_layout_rx_rw_checker_core.sv
verif/segment_layout_rx_rw_checker_core_test.sv
